### rtl/lz4fd_pkg.sv
// ----------------------------------------------------------------------------
// lz4fd_pkg - shared types and constants
// Item and result records, request and status codes of the frame decoder.
// ----------------------------------------------------------------------------
package lz4fd_pkg;

  localparam int unsigned HIST_AW = 16;
  localparam logic [16:0] HIST_BYTES = 17'd65536;
  localparam logic [31:0] LZ4_MAGIC = 32'h184D2204;

  localparam logic [1:0] FN_BYTE    = 2'd0;
  localparam logic [1:0] FN_CONT    = 2'd1;
  localparam logic [1:0] FN_RESTART = 2'd2;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_FLAGS   = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;
  localparam logic [2:0] ST_OFFSET  = 3'd5;
  localparam logic [2:0] ST_OVERRUN = 3'd6;
  localparam logic [2:0] ST_SEQ     = 3'd7;

  typedef struct packed {
    logic       is_byte;
    logic       is_cont;
    logic       is_restart;
    logic [7:0] data;
    logic       last;
  } lz4fd_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic [2:0] status;
  } lz4fd_res_t;

endpackage

### rtl/lz4fd_front.sv
// ----------------------------------------------------------------------------
// lz4fd_front - input queue and request decode
// Two-entry queue of incoming transactions, decoded into request kinds.
// ----------------------------------------------------------------------------
module lz4fd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [1:0]            func,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  full,
  output logic                  item_valid,
  output lz4fd_pkg::lz4fd_item_t item,
  input  logic                  take
);
  import lz4fd_pkg::*;

  lz4fd_item_t q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  lz4fd_item_t dec;
  logic        do_push, do_pop;

  always_comb begin
    dec.is_byte    = (func == FN_BYTE);
    dec.is_cont    = (func == FN_CONT);
    dec.is_restart = (func == FN_RESTART);
    dec.data       = data_byte;
    dec.last       = last_byte;
  end

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/lz4fd_back.sv
// ----------------------------------------------------------------------------
// lz4fd_back - frame parser and history engine
// Stage 1 walks the frame state; stage 2 reads history and forms the result.
// ----------------------------------------------------------------------------
module lz4fd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  lz4fd_pkg::lz4fd_item_t item,
  output logic                  take,
  input  logic                  adv,
  output logic                  res_valid,
  output lz4fd_pkg::lz4fd_res_t  res
);
  import lz4fd_pkg::*;

  localparam logic [3:0] PH_MAGIC  = 4'd0;
  localparam logic [3:0] PH_FLG    = 4'd1;
  localparam logic [3:0] PH_BD     = 4'd2;
  localparam logic [3:0] PH_HSKIP  = 4'd3;
  localparam logic [3:0] PH_BSIZE  = 4'd4;
  localparam logic [3:0] PH_RAW    = 4'd5;
  localparam logic [3:0] PH_TOKEN  = 4'd6;
  localparam logic [3:0] PH_LITEXT = 4'd7;
  localparam logic [3:0] PH_LIT    = 4'd8;
  localparam logic [3:0] PH_OFFLO  = 4'd9;
  localparam logic [3:0] PH_OFFHI  = 4'd10;
  localparam logic [3:0] PH_MATEXT = 4'd11;
  localparam logic [3:0] PH_COPY   = 4'd12;
  localparam logic [3:0] PH_BCSUM  = 4'd13;
  localparam logic [3:0] PH_CCSUM  = 4'd14;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  gc_r, gc_nxt;
  logic [31:0] gw_r, gw_nxt, gw_upd;
  logic [2:0]  flags_r, flags_nxt;
  logic [30:0] bl_r, bl_nxt;
  logic [3:0]  mn_r, mn_nxt;
  logic [31:0] rl_r, rl_nxt;
  logic [15:0] off_r, off_nxt;
  logic [31:0] cl_r, cl_nxt;
  logic [15:0] ptr_r, ptr_nxt;
  logic [16:0] fill_r, fill_nxt;
  logic [2:0]  st_r, st_nxt;

  logic        fire;
  logic        has1, cp1, we1;
  logic [7:0]  lbyte1;
  logic [15:0] src1;
  logic        do_litlen, do_lits, do_bend;
  logic [32:0] sat_sum;
  logic [31:0] rl_sat;
  logic [7:0]  b;

  logic        s2_v_r, s2_has_r, s2_cp_r, s2_we_r, s2_pend_r, s2_fwd_r;
  logic [7:0]  s2_lbyte_r, s2_fwd_data_r, mem_q_r, s2_byte;
  logic [15:0] s2_waddr_r;
  logic [2:0]  s2_st_r;

  logic [7:0]  hist_mem [HIST_BYTES];

  assign take = adv;
  assign fire = adv && item_valid;
  assign b    = item.data;

  always_comb begin
    gw_upd  = gw_r | ({24'd0, b} << {gc_r[1:0], 3'b000});
    sat_sum = {1'b0, rl_r} + {25'd0, b};
    rl_sat  = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
  end

  // frame walk, one transaction per cycle while the result queue has room
  always_comb begin
    phase_nxt = phase_r;  gc_nxt = gc_r;   gw_nxt = gw_r;   flags_nxt = flags_r;
    bl_nxt    = bl_r;     mn_nxt = mn_r;   rl_nxt = rl_r;   off_nxt   = off_r;
    cl_nxt    = cl_r;     ptr_nxt = ptr_r; fill_nxt = fill_r; st_nxt = st_r;
    has1 = 1'b0; cp1 = 1'b0; we1 = 1'b0; lbyte1 = 8'd0;
    src1 = ptr_r - off_r;
    do_litlen = 1'b0; do_lits = 1'b0; do_bend = 1'b0;

    if (item.is_restart) begin
      phase_nxt = PH_MAGIC; gc_nxt = 4'd0; gw_nxt = 32'd0; flags_nxt = 3'd0;
      bl_nxt = 31'd0; mn_nxt = 4'd0; rl_nxt = 32'd0; off_nxt = 16'd0;
      cl_nxt = 32'd0; ptr_nxt = 16'd0; fill_nxt = 17'd0; st_nxt = ST_BUSY;
    end else if (st_r != ST_BUSY || !(item.is_byte || item.is_cont)) begin
      // sticky end or unused request: nothing moves
    end else if (item.is_cont) begin
      if (phase_r != PH_COPY) begin
        st_nxt = ST_SEQ;
      end else begin
        cp1 = 1'b1; has1 = 1'b1; we1 = 1'b1;
        cl_nxt = cl_r - 32'd1;
        if (cl_nxt == 32'd0) begin
          if (bl_r == 31'd0) do_bend = 1'b1;
          else phase_nxt = PH_TOKEN;
        end
      end
    end else begin
      unique case (phase_r)
        PH_MAGIC: begin
          gw_nxt = gw_upd;
          gc_nxt = gc_r + 4'd1;
          if (gc_r == 4'd3) begin
            if (gw_upd != LZ4_MAGIC) st_nxt = ST_MAGIC;
            else phase_nxt = PH_FLG;
          end
        end
        PH_FLG: begin
          if (b[7:6] != 2'b01) begin
            st_nxt = ST_FLAGS;
          end else begin
            flags_nxt = {b[0], b[2], b[4]};
            gc_nxt    = 4'd1 + (b[3] ? 4'd8 : 4'd0) + (b[0] ? 4'd4 : 4'd0);
            phase_nxt = PH_BD;
          end
        end
        PH_BD: phase_nxt = PH_HSKIP;
        PH_HSKIP, PH_BCSUM: begin
          gc_nxt = gc_r - 4'd1;
          if (gc_r == 4'd1) begin
            phase_nxt = PH_BSIZE; gc_nxt = 4'd0; gw_nxt = 32'd0;
          end
        end
        PH_BSIZE: begin
          gw_nxt = gw_upd;
          gc_nxt = gc_r + 4'd1;
          if (gc_r == 4'd3) begin
            if (gw_upd == 32'd0) begin
              if (flags_r[1]) begin
                phase_nxt = PH_CCSUM; gc_nxt = 4'd4;
              end else begin
                st_nxt = ST_DONE;
              end
            end else begin
              bl_nxt = gw_upd[30:0];
              if (gw_upd[31]) begin
                if (gw_upd[30:0] == 31'd0) do_bend = 1'b1;
                else phase_nxt = PH_RAW;
              end else begin
                ptr_nxt = 16'd0; fill_nxt = 17'd0; phase_nxt = PH_TOKEN;
              end
            end
          end
        end
        PH_RAW: begin
          has1 = 1'b1; lbyte1 = b;
          bl_nxt = bl_r - 31'd1;
          if (bl_nxt == 31'd0) do_bend = 1'b1;
        end
        PH_TOKEN: begin
          mn_nxt = b[3:0];
          bl_nxt = bl_r - 31'd1;
          if (b[7:4] == 4'hF) begin
            rl_nxt = 32'd15;
            if (bl_nxt == 31'd0) st_nxt = ST_OVERRUN;
            else phase_nxt = PH_LITEXT;
          end else begin
            rl_nxt = {28'd0, b[7:4]};
            do_litlen = 1'b1;
          end
        end
        PH_LITEXT: begin
          rl_nxt = rl_sat;
          bl_nxt = bl_r - 31'd1;
          if (b == 8'hFF) begin
            if (bl_nxt == 31'd0) st_nxt = ST_OVERRUN;
          end else begin
            do_litlen = 1'b1;
          end
        end
        PH_LIT: begin
          has1 = 1'b1; we1 = 1'b1; lbyte1 = b;
          bl_nxt = bl_r - 31'd1;
          rl_nxt = rl_r - 32'd1;
          if (rl_nxt == 32'd0) do_lits = 1'b1;
        end
        PH_OFFLO: begin
          off_nxt = {8'd0, b};
          bl_nxt  = bl_r - 31'd1;
          phase_nxt = PH_OFFHI;
        end
        PH_OFFHI: begin
          off_nxt = {b, off_r[7:0]};
          bl_nxt  = bl_r - 31'd1;
          if (off_nxt == 16'd0 || {1'b0, off_nxt} > fill_r) begin
            st_nxt = ST_OFFSET;
          end else begin
            rl_nxt = {28'd0, mn_r} + 32'd4;
            if (mn_r == 4'hF) begin
              if (bl_nxt == 31'd0) st_nxt = ST_OVERRUN;
              else phase_nxt = PH_MATEXT;
            end else begin
              cl_nxt = rl_nxt; phase_nxt = PH_COPY;
            end
          end
        end
        PH_MATEXT: begin
          rl_nxt = rl_sat;
          bl_nxt = bl_r - 31'd1;
          if (b != 8'hFF) begin
            cl_nxt = rl_nxt; phase_nxt = PH_COPY;
          end else if (bl_nxt == 31'd0) begin
            st_nxt = ST_OVERRUN;
          end
        end
        PH_CCSUM: begin
          gc_nxt = gc_r - 4'd1;
          if (gc_r == 4'd1) st_nxt = ST_DONE;
        end
        default: st_nxt = ST_SEQ;  // frame byte while a copy is pending
      endcase

      if (do_litlen) begin
        if (rl_nxt > {1'b0, bl_nxt}) st_nxt = ST_OVERRUN;
        else if (rl_nxt == 32'd0) do_lits = 1'b1;
        else phase_nxt = PH_LIT;
      end
      if (do_lits) begin
        if (bl_nxt == 31'd0) do_bend = 1'b1;
        else if (bl_nxt < 31'd2) st_nxt = ST_OVERRUN;
        else phase_nxt = PH_OFFLO;
      end
    end

    if (do_bend) begin
      if (flags_r[0]) begin
        phase_nxt = PH_BCSUM; gc_nxt = 4'd4;
      end else begin
        phase_nxt = PH_BSIZE; gc_nxt = 4'd0; gw_nxt = 32'd0;
      end
    end

    if (we1) begin
      ptr_nxt = ptr_r + 16'd1;
      if (fill_r < HIST_BYTES) fill_nxt = fill_r + 17'd1;
    end

    if (item.is_byte && !item.is_restart && st_r == ST_BUSY && st_nxt == ST_BUSY &&
        item.last) begin
      st_nxt = ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; gc_r <= 4'd0; gw_r <= 32'd0; flags_r <= 3'd0;
      bl_r <= 31'd0; mn_r <= 4'd0; rl_r <= 32'd0; off_r <= 16'd0;
      cl_r <= 32'd0; ptr_r <= 16'd0; fill_r <= 17'd0; st_r <= ST_BUSY;
    end else if (fire) begin
      phase_r <= phase_nxt; gc_r <= gc_nxt; gw_r <= gw_nxt; flags_r <= flags_nxt;
      bl_r <= bl_nxt; mn_r <= mn_nxt; rl_r <= rl_nxt; off_r <= off_nxt;
      cl_r <= cl_nxt; ptr_r <= ptr_nxt; fill_r <= fill_nxt; st_r <= st_nxt;
    end
  end

  // stage 2: copy byte comes from memory, or from the byte just written
  assign s2_byte = s2_cp_r ? (s2_fwd_r ? s2_fwd_data_r : mem_q_r) : s2_lbyte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= fire;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_has_r      <= has1;
      s2_cp_r       <= cp1;
      s2_we_r       <= we1;
      s2_lbyte_r    <= lbyte1;
      s2_waddr_r    <= ptr_r;
      s2_pend_r     <= (st_nxt == ST_BUSY) && (phase_nxt == PH_COPY);
      s2_st_r       <= st_nxt;
      s2_fwd_r      <= cp1 && s2_v_r && s2_we_r && (s2_waddr_r == src1);
      s2_fwd_data_r <= s2_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_v_r && s2_we_r) hist_mem[s2_waddr_r] <= s2_byte;
      mem_q_r <= hist_mem[src1];
    end
  end

  assign res_valid        = s2_v_r;
  assign res.has_byte     = s2_has_r;
  assign res.out_byte     = s2_has_r ? s2_byte : 8'd0;
  assign res.copy_pending = s2_pend_r;
  assign res.status       = s2_st_r;

`ifndef NO_ASSERTIONS
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_pend_r |-> s2_st_r == ST_BUSY) else $error("copy pending while ended");
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= HIST_BYTES) else $error("history fill past window");
  a_fwd_copy: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_fwd_r |-> s2_cp_r) else $error("forward on non-copy");
  a_copy_wr: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_cp_r |-> s2_has_r && s2_we_r) else $error("copy without write");
`endif

endmodule

### rtl/lz4fd_outq.sv
// ----------------------------------------------------------------------------
// lz4fd_outq - result queue
// Two-entry queue that holds results until the consumer pops them.
// ----------------------------------------------------------------------------
module lz4fd_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  input  lz4fd_pkg::lz4fd_res_t wr_res,
  output logic                 adv,
  output logic                 empty,
  output lz4fd_pkg::lz4fd_res_t rd_res,
  input  logic                 pop
);
  import lz4fd_pkg::*;

  lz4fd_res_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign adv     = (cnt_r != 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_res  = q_r[rp_r];
  assign do_push = wr_valid && adv;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= wr_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/lz4_frame_decompressor.sv
// ----------------------------------------------------------------------------
// lz4_frame_decompressor - LZ4 frame decoder, one byte per transaction
// Parses the frame header, passes raw blocks, decodes compressed sequences.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in_      in_push / in_full   in_func, in_data_byte, in_last_byte
//  out_     out_pop / out_empty out_has_byte, out_out_byte, out_copy_pending,
//                               out_status
//
//  One transaction per cycle sustained while the result queue has room; every
//  input gives one result, registered through the input queue, the parse
//  stage with history read, then the result queue.
//  Match bytes come from a 64 KiB history RAM, one read port; a byte whose
//  write is pending is forwarded: back-to-back offset-1 copies run at rate.
//  rst_n is synchronous; the history RAM is not cleared (only bytes of the
//  current block are ever read).
//  Holding out_pop low fills the result queue, then the engine and input
//  queue freeze and in_full rises.
// ----------------------------------------------------------------------------
module lz4_frame_decompressor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_has_byte,
  output logic [7:0] out_out_byte,
  output logic       out_copy_pending,
  output logic [2:0] out_status
);
  import lz4fd_pkg::*;

  lz4fd_item_t item;
  lz4fd_res_t  res, rd_res;
  logic        item_valid, take, adv, res_valid;

  // front: accept and decode requests
  lz4fd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .func       (in_func),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .full       (in_full),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // back: frame parser, history RAM
  lz4fd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .adv        (adv),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result queue decouples the consumer
  lz4fd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_res   (res),
    .adv      (adv),
    .empty    (out_empty),
    .rd_res   (rd_res),
    .pop      (out_pop)
  );

  assign out_has_byte     = rd_res.has_byte;
  assign out_out_byte     = rd_res.out_byte;
  assign out_copy_pending = rd_res.copy_pending;
  assign out_status       = rd_res.status;

endmodule

### tb/sv/tb_lz4_frame_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz4_frame_decompressor - self-checking bench for the LZ4 frame decoder
// Directed table of header, error and request cases, then random frames
// (raw and compressed blocks, matches with continue transactions, mutated
// frames) under several idle/stall mixes, checked against a local decoder.
// ----------------------------------------------------------------------------
module tb_lz4_frame_decompressor;
  import lz4fd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [3:0] {
    P_MAGIC, P_FLG, P_BD, P_HSKIP, P_BSIZE, P_RAW, P_TOKEN, P_LITEXT,
    P_LIT, P_OFFLO, P_OFFHI, P_MATEXT, P_COPY, P_BCSUM, P_CCSUM
  } dec_phase_t;

  // One input transaction; rows of the directed table may carry a typed
  // expectation (typed = 1), everything else is checked against the decoder.
  typedef struct {
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
    bit         typed;
    lz4fd_res_t want;
  } frame_txn_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [1:0] in_func = FN_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic       out_has_byte;
  logic [7:0] out_out_byte;
  logic       out_copy_pending;
  logic [2:0] out_status;

  always #10 clk = ~clk;

  lz4_frame_decompressor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_func(in_func),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_empty(out_empty), .out_pop(out_pop), .out_has_byte(out_has_byte),
    .out_out_byte(out_out_byte), .out_copy_pending(out_copy_pending),
    .out_status(out_status)
  );

  frame_txn_t txn_q[$];        // transactions waiting to be offered
  lz4fd_res_t decoded_q[$];    // expected results, oldest first
  int  errors = 0;
  int  cycles = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;          // long receiver hold-off, cycles remaining
  bit  running = 1'b0;

  // --------------------------------------------------------------------------
  // Decoder state (mirrors the block's architectural state)
  // --------------------------------------------------------------------------
  dec_phase_t  ph;
  int unsigned g_cnt;
  logic [31:0] g_word;
  logic [2:0]  fflags;         // bit0 block csum, bit1 content csum, bit2 dict id
  logic [31:0] blk_left;
  logic [3:0]  mnib;
  logic [31:0] run_len;
  logic [31:0] moff;
  logic [31:0] copy_left;
  logic [15:0] hptr;
  int unsigned hfill;
  logic [7:0]  hist [65536];
  logic [2:0]  fstat;

  function automatic void append_txn(ref frame_txn_t q[$], input frame_txn_t t);
    q = {q, t};
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void dec_reset();
    ph = P_MAGIC; g_cnt = 0; g_word = '0; fflags = '0; blk_left = '0;
    mnib = '0; run_len = '0; moff = '0; copy_left = '0; hptr = '0;
    hfill = 0; fstat = ST_BUSY;
  endfunction

  function void hist_put(logic [7:0] b);
    hist[hptr] = b;
    hptr = hptr + 16'd1;
    if (hfill < 65536) hfill++;
  endfunction

  function void go_bsize();
    ph = P_BSIZE; g_cnt = 0; g_word = '0;
  endfunction

  function void block_end();
    if (fflags[0]) begin
      ph = P_BCSUM; g_cnt = 4;
    end else begin
      go_bsize();
    end
  endfunction

  function void after_lits();
    if (blk_left == 0) block_end();
    else if (blk_left < 2) fstat = ST_OVERRUN;
    else ph = P_OFFLO;
  endfunction

  function void after_litlen();
    if (run_len > blk_left) fstat = ST_OVERRUN;
    else if (run_len == 0) after_lits();
    else ph = P_LIT;
  endfunction

  // Consume one frame byte; returns 1 when a decompressed byte comes out.
  function automatic bit take_byte(logic [7:0] b, output logic [7:0] ob);
    ob = 8'h00;
    case (ph)
      P_MAGIC: begin
        g_word = g_word | (32'(b) << (8 * (g_cnt & 3)));
        g_cnt++;
        if (g_cnt == 4) begin
          if (g_word != LZ4_MAGIC) fstat = ST_MAGIC;
          else ph = P_FLG;
        end
      end
      P_FLG: begin
        if ((b & 8'hC0) != 8'h40) begin
          fstat = ST_FLAGS;
        end else begin
          fflags = {b[0], b[2], b[4]};
          g_cnt = 1 + (b[3] ? 8 : 0) + (b[0] ? 4 : 0);
          ph = P_BD;
        end
      end
      P_BD: ph = P_HSKIP;
      P_HSKIP: begin
        g_cnt--;
        if (g_cnt == 0) go_bsize();
      end
      P_BSIZE: begin
        g_word = g_word | (32'(b) << (8 * (g_cnt & 3)));
        g_cnt++;
        if (g_cnt >= 4) begin
          if (g_word == 0) begin
            if (fflags[1]) begin
              ph = P_CCSUM; g_cnt = 4;
            end else begin
              fstat = ST_DONE;
            end
          end else begin
            blk_left = {1'b0, g_word[30:0]};
            if (g_word[31]) begin
              if (blk_left == 0) block_end();
              else ph = P_RAW;
            end else begin
              hptr = '0; hfill = 0; ph = P_TOKEN;
            end
          end
        end
      end
      P_RAW: begin
        ob = b;
        blk_left--;
        if (blk_left == 0) block_end();
        return 1'b1;
      end
      P_TOKEN: begin
        mnib = b[3:0];
        blk_left--;
        run_len = 32'(b[7:4]);
        if (b[7:4] == 4'hF) begin
          if (blk_left == 0) fstat = ST_OVERRUN;
          else ph = P_LITEXT;
        end else begin
          after_litlen();
        end
      end
      P_LITEXT: begin
        run_len = sat_add(run_len, 32'(b));
        blk_left--;
        if (b == 8'hFF) begin
          if (blk_left == 0) fstat = ST_OVERRUN;
        end else begin
          after_litlen();
        end
      end
      P_LIT: begin
        ob = b;
        hist_put(b);
        blk_left--;
        run_len--;
        if (run_len == 0) after_lits();
        return 1'b1;
      end
      P_OFFLO: begin
        moff = 32'(b);
        blk_left--;
        ph = P_OFFHI;
      end
      P_OFFHI: begin
        moff = moff | (32'(b) << 8);
        blk_left--;
        if (moff == 0 || moff > hfill) begin
          fstat = ST_OFFSET;
        end else begin
          run_len = 32'(mnib) + 4;
          if (mnib == 4'hF) begin
            if (blk_left == 0) fstat = ST_OVERRUN;
            else ph = P_MATEXT;
          end else begin
            copy_left = run_len; ph = P_COPY;
          end
        end
      end
      P_MATEXT: begin
        run_len = sat_add(run_len, 32'(b));
        blk_left--;
        if (b != 8'hFF) begin
          copy_left = run_len; ph = P_COPY;
        end else if (blk_left == 0) begin
          fstat = ST_OVERRUN;
        end
      end
      P_BCSUM: begin
        g_cnt--;
        if (g_cnt == 0) go_bsize();
      end
      P_CCSUM: begin
        g_cnt--;
        if (g_cnt == 0) fstat = ST_DONE;
      end
      default: fstat = ST_SEQ;
    endcase
    return 1'b0;
  endfunction

  // Expected result of one accepted transaction.
  function automatic lz4fd_res_t decode_txn(logic [1:0] func, logic [7:0] b, logic last);
    lz4fd_res_t r;
    logic [7:0] ob;
    bit has;
    ob = 8'h00;
    has = 1'b0;
    if (func == FN_RESTART) begin
      dec_reset();
    end else if (func == FN_CONT && fstat == ST_BUSY) begin
      if (ph != P_COPY) begin
        fstat = ST_SEQ;
      end else begin
        ob = hist[hptr - moff[15:0]];
        hist_put(ob);
        has = 1'b1;
        copy_left--;
        if (copy_left == 0) begin
          if (blk_left == 0) block_end();
          else ph = P_TOKEN;
        end
      end
    end else if (func == FN_BYTE && fstat == ST_BUSY) begin
      if (ph == P_COPY) fstat = ST_SEQ;
      else has = take_byte(b, ob);
      if (fstat == ST_BUSY && last) fstat = ST_TRUNC;
    end
    // func 3 and anything after a nonzero status: no state change
    r.has_byte = has;
    r.out_byte = has ? ob : 8'h00;
    r.copy_pending = (fstat == ST_BUSY && ph == P_COPY);
    r.status = fstat;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic frame_txn_t mk(logic [1:0] f, logic [7:0] d, logic l);
    frame_txn_t t;
    t.func = f; t.data = d; t.last = l; t.typed = 1'b0; t.want = '0;
    return t;
  endfunction

  function automatic frame_txn_t mkx(logic [1:0] f, logic [7:0] d, logic l,
                                     logic [2:0] st);
    frame_txn_t t;
    t = mk(f, d, l);
    t.typed = 1'b1;
    t.want = '{has_byte: 1'b0, out_byte: 8'h00, copy_pending: 1'b0, status: st};
    return t;
  endfunction

  // Length extension bytes for a length field that saturated its nibble.
  function automatic void put_ext(ref frame_txn_t q[$], input int unsigned rem);
    while (rem >= 255) begin
      append_txn(q, mk(FN_BYTE, 8'hFF, 1'b0));
      rem -= 255;
    end
    append_txn(q, mk(FN_BYTE, 8'(rem), 1'b0));
  endfunction

  function automatic int unsigned pick_len(int unsigned lo);
    if ($urandom_range(9) == 0) return $urandom_range(300, 15);
    return $urandom_range(20, lo);
  endfunction

  // Compressed block body: sequences, continue transactions after each match.
  function automatic void put_cblock(ref frame_txn_t q[$]);
    frame_txn_t body[$];
    int unsigned nbytes, fill, nseq, lits, mlen, off;
    nbytes = 0; fill = 0;
    nseq = $urandom_range(3);
    for (int s = 0; s <= nseq; s++) begin
      bit tail;
      tail = (s == nseq);
      lits = pick_len(fill == 0 ? 1 : 0);
      mlen = pick_len(4);
      append_txn(body, mk(FN_BYTE, {(lits >= 15) ? 4'hF : 4'(lits),
                                    tail ? 4'h0 : ((mlen - 4 >= 15) ? 4'hF : 4'(mlen - 4))},
                          1'b0));
      if (lits >= 15) put_ext(body, lits - 15);
      for (int i = 0; i < lits; i++) append_txn(body, mk(FN_BYTE, 8'($urandom), 1'b0));
      fill += lits;
      if (!tail) begin
        off = $urandom_range(fill > 65535 ? 65535 : fill, 1);
        if ($urandom_range(49) == 0) off = $urandom_range(1) ? 0 : fill + 1;
        append_txn(body, mk(FN_BYTE, off[7:0], 1'b0));
        append_txn(body, mk(FN_BYTE, off[15:8], 1'b0));
        if (mlen - 4 >= 15) put_ext(body, mlen - 19);
        for (int i = 0; i < mlen; i++)
          append_txn(body, mk(FN_CONT, 8'($urandom), 1'($urandom)));
        fill += mlen;
      end
    end
    foreach (body[i]) if (body[i].func == FN_BYTE) nbytes++;
    for (int i = 0; i < 4; i++) append_txn(q, mk(FN_BYTE, nbytes[8*i +: 8], 1'b0));
    foreach (body[i]) append_txn(q, body[i]);
  endfunction

  // One frame, restart first; some frames get mutated to hit error paths.
  function automatic int build_frame();
    frame_txn_t q[$];
    logic [7:0] flg;
    int unsigned nblk, n, k;
    append_txn(q, mk(FN_RESTART, 8'($urandom), 1'($urandom)));
    for (int i = 0; i < 4; i++) append_txn(q, mk(FN_BYTE, LZ4_MAGIC[8*i +: 8], 1'b0));
    flg = 8'h40 | (8'($urandom) & 8'h3F);
    append_txn(q, mk(FN_BYTE, flg, 1'b0));
    append_txn(q, mk(FN_BYTE, 8'($urandom), 1'b0));      // BD
    n = 1 + (flg[3] ? 8 : 0) + (flg[0] ? 4 : 0);
    for (int i = 0; i < n; i++) append_txn(q, mk(FN_BYTE, 8'($urandom), 1'b0));
    nblk = $urandom_range(2);
    for (int b = 0; b <= nblk; b++) begin
      if ($urandom_range(4) < 2) begin
        n = $urandom_range(20);                         // raw, empty allowed
        for (int i = 0; i < 4; i++)
          append_txn(q, mk(FN_BYTE, i == 3 ? 8'h80 : (i == 0 ? 8'(n) : 8'h00), 1'b0));
        for (int i = 0; i < n; i++) append_txn(q, mk(FN_BYTE, 8'($urandom), 1'b0));
      end else begin
        put_cblock(q);
      end
      if (flg[4])
        for (int i = 0; i < 4; i++) append_txn(q, mk(FN_BYTE, 8'($urandom), 1'b0));
    end
    for (int i = 0; i < 4; i++) append_txn(q, mk(FN_BYTE, 8'h00, 1'b0));
    if (flg[2])
      for (int i = 0; i < 4; i++) append_txn(q, mk(FN_BYTE, 8'($urandom), 1'b0));
    q[$].last = 1'b1;
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(q.size() - 1, 1);
      case ($urandom_range(4))
        0: q[k].data = q[k].data ^ (8'h01 << $urandom_range(7));
        1: q[k].last = 1'b1;
        2: q.insert(k, mk(FN_CONT, 8'($urandom), 1'b0));
        3: q.insert(k, mk(2'd3, 8'($urandom), 1'($urandom)));
        default: for (int i = 0; i < 3; i++)
                   append_txn(q, mk(FN_BYTE, 8'($urandom), 1'($urandom)));
      endcase
    end
    foreach (q[i]) append_txn(txn_q, q[i]);
    return q.size();
  endfunction

  // --------------------------------------------------------------------------
  // Drivers and checker
  // --------------------------------------------------------------------------
  // Sender: the head of txn_q is what is on the port; held until accepted.
  always @(posedge clk) begin
    bit taken;
    taken = in_push && !in_full;
    if (taken) begin
      frame_txn_t t;
      lz4fd_res_t r;
      t = txn_q.pop_front();
      r = decode_txn(t.func, t.data, t.last);
      decoded_q = {decoded_q, (t.typed ? t.want : r)};
    end
    if (running && txn_q.size() > 0 &&
        ((in_push && !taken) || $urandom_range(99) >= idle_pct)) begin
      in_push <= 1'b1;
      in_func <= txn_q[0].func;
      in_data_byte <= txn_q[0].data;
      in_last_byte <= txn_q[0].last;
    end else begin
      in_push <= 1'b0;
    end
  end

  // Long hold-off of the receiver, counted on its own.
  always @(posedge clk) if (hold_left > 0) hold_left <= hold_left - 1;

  always @(posedge clk)
    out_pop <= running && hold_left == 0 && $urandom_range(99) >= stall_pct;

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH @%0d %s: got %0h expected %0h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      if (decoded_q.size() == 0) begin
        report("unexpected transaction", out_status, 0);
      end else begin
        lz4fd_res_t w;
        w = decoded_q.pop_front();
        if (out_has_byte !== w.has_byte) report("has_byte", out_has_byte, w.has_byte);
        if (out_out_byte !== w.out_byte) report("out_byte", out_out_byte, w.out_byte);
        if (out_copy_pending !== w.copy_pending)
          report("copy_pending", out_copy_pending, w.copy_pending);
        if (out_status !== w.status) report("status", out_status, w.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    while (txn_q.size() > 0 || decoded_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    frame_txn_t dir[$];
    int budget;
    dec_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    running = 1'b1;

    // Directed: request errors, unused func, header errors, truncation.
    dir = '{
      mkx(FN_CONT, 8'h00, 1'b0, ST_SEQ),          // continue with no copy
      mkx(FN_BYTE, 8'hFF, 1'b1, ST_SEQ),          // sticky: ignored
      mkx(FN_RESTART, 8'hFF, 1'b1, ST_BUSY),
      mkx(2'd3, 8'hAA, 1'b1, ST_BUSY),            // unused func
      mkx(FN_BYTE, 8'h04, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'h22, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'h4D, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'h18, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'h80, 1'b0, ST_FLAGS),        // version bits wrong
      mkx(FN_RESTART, 8'h00, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'hFF, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'hFF, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'hFF, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'hFF, 1'b0, ST_MAGIC),
      mkx(FN_RESTART, 8'h00, 1'b0, ST_BUSY),
      mkx(FN_BYTE, 8'h04, 1'b1, ST_TRUNC),        // last mark mid-header
      mkx(FN_CONT, 8'h00, 1'b0, ST_TRUNC),
      mkx(FN_RESTART, 8'h00, 1'b0, ST_BUSY)
    };
    foreach (dir[i]) append_txn(txn_q, dir[i]);
    drain();

    // Random phases: no idling, sender idle, receiver stalls, both, pressure.
    for (int p = 0; p < 5; p++) begin
      idle_pct  = (p == 1) ? 63 : (p == 3) ? 36 : 0;
      stall_pct = (p == 2) ? 63 : (p == 3) ? 36 : 0;
      if (p == 4) hold_left = 400;
      budget = 220;
      while (budget > 0) budget -= build_frame();
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
